[hw/rtl/sln_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sln_pkg: shared types and constants for the subject line normalizer
// prefix phases, sequencer states and sizing of the counters and buffer
// ----------------------------------------------------------------------------
package sln_pkg;

    localparam int MAX_OUT    = 512;
    localparam int CNT_W      = $clog2(MAX_OUT);
    localparam int OUT_LIMIT  = MAX_OUT - 1;
    localparam int LEN_W      = 9;
    localparam int BUF_DEPTH  = 18;
    localparam int BUF_AW     = $clog2(BUF_DEPTH);
    localparam int SCAN_W     = $clog2(BUF_DEPTH + 1);
    localparam int WORD_LIMIT = 8;
    localparam int TAG_LIMIT  = 16;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_RBRK  = 8'h5d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_S     = 8'h73;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // prefix / output phase of the normalizer
    typedef enum logic [2:0] {
        PH_SKIPWS,
        PH_WORD,
        PH_TAG,
        PH_EMIT,
        PH_FULL,
        PH_DONE
    } t_phase;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_REPLAY,
        S_BYTE,
        S_END,
        S_FLUSH
    } t_seq;

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) || (b == CH_TAB);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        is_alnum = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a)
                || (b >= 8'h30 && b <= 8'h39);
    endfunction

    function automatic logic [7:0] low_case(input logic [7:0] b);
        low_case = (b >= 8'h41 && b <= 8'h5a) ? (b | 8'h20) : b;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/subject_line_normalizer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// subject_line_normalizer: canonical subject line, one byte word at a time
// skips reply/forward prefixes and bracketed tags, then lowercases alnum,
// drops punctuation and folds whitespace into single spaces
// ----------------------------------------------------------------------------
// sequence: a word is captured in S_IDLE, decided in S_DECIDE, then each
//   output step of the shared byte unit runs in S_REPLAY or S_BYTE (a byte
//   with a pending space is revisited); S_FLUSH marks the last result
// input: one word at a time, as o_in_stall holds new words until S_IDLE;
//   a prefix break replays up to 18 buffered bytes
// reset: synchronous active-low i_rst_n clears sequencer, phase, counters and
//   output valid; the replay buffer is not cleared

module subject_line_normalizer (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [7:0]                i_in_byte,
    input  wire logic                      i_in_end,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic                           o_out_kind,
    output logic [7:0]                     o_out_char,
    output logic [sln_pkg::LEN_W-1:0]      o_out_length,
    output logic                           o_out_last_of_run
);

    localparam int CW = sln_pkg::CNT_W;
    localparam int SW = sln_pkg::SCAN_W;
    localparam int AW = sln_pkg::BUF_AW;
    localparam int LW = sln_pkg::LEN_W;

    // sequencer and model state
    sln_pkg::t_seq   r_seq, n_seq;
    sln_pkg::t_phase r_phase, n_phase;
    logic [SW-1:0]   r_scan, n_scan;
    logic [CW-1:0]   r_written, n_written;
    logic [CW-1:0]   r_lastsp, n_lastsp;
    logic            r_pending, n_pending;
    logic            r_rewind, n_rewind;
    logic [23:0]     r_recent, n_recent;

    // replay buffer of the candidate prefix word
    logic [7:0]      r_buf [sln_pkg::BUF_DEPTH];
    logic            w_store;
    logic [7:0]      w_store_byte;

    // captured input word and replay control
    logic [7:0]      r_cur_byte, n_cur_byte;
    logic            r_cur_end, n_cur_end;
    logic [AW-1:0]   r_idx, n_idx;
    logic [SW-1:0]   r_count, n_count;

    // one-deep hold so the last result of a word can be flagged
    logic            r_hold_valid, n_hold_valid;
    logic            r_hold_kind, n_hold_kind;
    logic [7:0]      r_hold_char, n_hold_char;
    logic [LW-1:0]   r_hold_len, n_hold_len;

    // output register
    logic            r_out_valid, n_out_valid;
    logic            r_out_kind, n_out_kind;
    logic [7:0]      r_out_char, n_out_char;
    logic [LW-1:0]   r_out_len, n_out_len;
    logic            r_out_last, n_out_last;

    logic            w_accept;
    logic            w_slot;
    logic            w_go;
    logic            w_brk;
    logic            w_flush;
    logic            w_res_valid;
    logic            w_res_kind;
    logic [7:0]      w_res_char;
    logic [LW-1:0]   w_res_len;

    // shared byte unit results
    logic [7:0]      w_b;
    logic            s_res;
    logic [7:0]      s_char;
    logic            s_done;
    sln_pkg::t_phase s_phase;
    logic [CW-1:0]   s_written;
    logic [CW-1:0]   s_lastsp;
    logic            s_pending;
    logic            s_rewind;
    logic [23:0]     s_recent;
    logic            s_was;

    // prefix decision scratch
    sln_pkg::t_phase p_phase;
    logic [SW-1:0]   p_scan;

    assign o_in_stall        = (r_seq != sln_pkg::S_IDLE);
    assign w_accept          = i_in_valid && !o_in_stall;
    assign w_slot            = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_kind        = r_out_kind;
    assign o_out_char        = r_out_char;
    assign o_out_length      = r_out_len;
    assign o_out_last_of_run = r_out_last;

    assign w_b = (r_seq == sln_pkg::S_REPLAY) ? r_buf[r_idx] : r_cur_byte;

    // shared byte unit: one output step of one byte per cycle while the output path is not stalled
    always_comb begin
        s_res     = 1'b0;
        s_char    = w_b;
        s_done    = 1'b1;
        s_phase   = r_phase;
        s_written = r_written;
        s_lastsp  = r_lastsp;
        s_pending = r_pending;
        s_rewind  = r_rewind;
        s_recent  = {r_recent[15:0], w_b};
        s_was     = (sln_pkg::low_case(r_recent[23:16]) == sln_pkg::CH_W)
                 && (sln_pkg::low_case(r_recent[15:8]) == sln_pkg::CH_A)
                 && (sln_pkg::low_case(r_recent[7:0]) == sln_pkg::CH_S);
        case (r_phase)
            sln_pkg::PH_FULL: begin
                // byte right after a full output decides the rewind
                if (w_b == sln_pkg::CH_COLON) begin
                    s_rewind = 1'b1;
                end
                s_phase  = sln_pkg::PH_DONE;
                s_recent = r_recent;
            end
            sln_pkg::PH_EMIT: begin
                if (sln_pkg::is_blank(w_b)) begin
                    s_pending = 1'b1;
                end else if (w_b == sln_pkg::CH_COLON
                             && r_written > CW'(sln_pkg::WORD_LIMIT) && s_was) begin
                    s_phase  = sln_pkg::PH_DONE;
                    s_rewind = 1'b1;
                    s_recent = r_recent;
                end else if (sln_pkg::is_alnum(w_b)) begin
                    s_res     = 1'b1;
                    s_written = r_written + CW'(1);
                    if (r_pending) begin
                        // pending space goes first, byte is revisited next step
                        s_char    = sln_pkg::CH_SPACE;
                        s_lastsp  = r_written;
                        s_pending = 1'b0;
                        s_recent  = r_recent;
                        if (s_written == CW'(sln_pkg::OUT_LIMIT)) begin
                            s_phase = sln_pkg::PH_DONE;
                        end else begin
                            s_done = 1'b0;
                        end
                    end else begin
                        s_char = sln_pkg::low_case(w_b);
                        if (s_written == CW'(sln_pkg::OUT_LIMIT)) begin
                            s_phase = sln_pkg::PH_FULL;
                        end
                    end
                end
            end
            default: begin
                s_recent = r_recent;
            end
        endcase
    end

    // datapath and handshake
    always_comb begin
        n_phase      = r_phase;
        n_scan       = r_scan;
        n_written    = r_written;
        n_lastsp     = r_lastsp;
        n_pending    = r_pending;
        n_rewind     = r_rewind;
        n_recent     = r_recent;
        n_cur_byte   = r_cur_byte;
        n_cur_end    = r_cur_end;
        n_idx        = r_idx;
        n_count      = r_count;
        n_hold_valid = r_hold_valid;
        n_hold_kind  = r_hold_kind;
        n_hold_char  = r_hold_char;
        n_hold_len   = r_hold_len;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_char   = r_out_char;
        n_out_len    = r_out_len;
        n_out_last   = r_out_last;
        w_store      = 1'b0;
        w_store_byte = r_cur_byte;
        w_brk        = 1'b0;
        w_flush      = 1'b0;
        w_res_valid  = 1'b0;
        w_res_kind   = sln_pkg::KIND_CHAR;
        w_res_char   = s_char;
        w_res_len    = '0;
        p_phase      = r_phase;
        p_scan       = r_scan;
        w_go         = 1'b1;

        case (r_seq)
            sln_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cur_byte = i_in_byte;
                    n_cur_end  = i_in_end;
                end
            end
            sln_pkg::S_DECIDE: begin
                if (r_phase == sln_pkg::PH_SKIPWS || r_phase == sln_pkg::PH_WORD
                    || r_phase == sln_pkg::PH_TAG) begin
                    if (r_cur_end) begin
                        // all-prefix subject: last candidate word is replayed
                        w_brk = 1'b1;
                    end else begin
                        if (r_phase == sln_pkg::PH_SKIPWS
                            && !sln_pkg::is_blank(r_cur_byte)) begin
                            p_scan  = '0;
                            p_phase = sln_pkg::PH_WORD;
                        end
                        if (p_phase == sln_pkg::PH_WORD) begin
                            if (r_cur_byte == sln_pkg::CH_LBRK && p_scan == '0) begin
                                p_phase = sln_pkg::PH_TAG;
                                w_store = 1'b1;
                            end else if (r_cur_byte == sln_pkg::CH_COLON) begin
                                p_phase = sln_pkg::PH_SKIPWS;
                                w_store = 1'b1;
                            end else if (r_cur_byte == sln_pkg::CH_SPACE
                                         || p_scan > SW'(sln_pkg::WORD_LIMIT)) begin
                                w_brk = 1'b1;
                            end else begin
                                w_store = 1'b1;
                            end
                        end else if (p_phase == sln_pkg::PH_TAG) begin
                            if (r_cur_byte == sln_pkg::CH_RBRK) begin
                                p_phase = sln_pkg::PH_SKIPWS;
                                w_store = 1'b1;
                            end else if (p_scan > SW'(sln_pkg::TAG_LIMIT)) begin
                                w_brk = 1'b1;
                            end else begin
                                w_store = 1'b1;
                            end
                        end
                    end
                    if (w_brk) begin
                        n_phase   = sln_pkg::PH_EMIT;
                        n_count   = p_scan;
                        n_idx     = '0;
                        n_scan    = '0;
                        n_written = '0;
                        n_lastsp  = '0;
                        n_pending = 1'b0;
                        n_rewind  = 1'b0;
                        n_recent  = '0;
                    end else begin
                        n_phase = p_phase;
                        n_scan  = w_store ? p_scan + SW'(1) : p_scan;
                    end
                end
            end
            sln_pkg::S_REPLAY, sln_pkg::S_BYTE: begin
                w_res_valid = s_res;
                w_go        = !s_res || !r_hold_valid || w_slot;
                if (w_go) begin
                    n_phase   = s_phase;
                    n_written = s_written;
                    n_lastsp  = s_lastsp;
                    n_pending = s_pending;
                    n_rewind  = s_rewind;
                    n_recent  = s_recent;
                    if (r_seq == sln_pkg::S_REPLAY && s_done) begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            sln_pkg::S_END: begin
                w_res_valid = 1'b1;
                w_res_kind  = sln_pkg::KIND_END;
                w_res_char  = '0;
                w_res_len   = (r_phase == sln_pkg::PH_DONE && r_rewind)
                            ? LW'(r_lastsp) : LW'(r_written);
                w_go        = !r_hold_valid || w_slot;
                if (w_go) begin
                    // back to the state after reset for the next subject
                    n_phase   = sln_pkg::PH_SKIPWS;
                    n_scan    = '0;
                    n_written = '0;
                    n_lastsp  = '0;
                    n_pending = 1'b0;
                    n_rewind  = 1'b0;
                    n_recent  = '0;
                end
            end
            sln_pkg::S_FLUSH: begin
                w_flush = r_hold_valid && w_slot;
            end
            default: begin
            end
        endcase

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_res_valid && w_go) begin
            // a newer result exists, so the held one is not the last
            if (r_hold_valid) begin
                n_out_valid = 1'b1;
                n_out_kind  = r_hold_kind;
                n_out_char  = r_hold_char;
                n_out_len   = r_hold_len;
                n_out_last  = 1'b0;
            end
            n_hold_valid = 1'b1;
            n_hold_kind  = w_res_kind;
            n_hold_char  = w_res_char;
            n_hold_len   = w_res_len;
        end else if (w_flush) begin
            n_out_valid  = 1'b1;
            n_out_kind   = r_hold_kind;
            n_out_char   = r_hold_char;
            n_out_len    = r_hold_len;
            n_out_last   = 1'b1;
            n_hold_valid = 1'b0;
        end
    end

    // sequencer next state
    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            sln_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_seq = sln_pkg::S_DECIDE;
                end
            end
            sln_pkg::S_DECIDE: begin
                if (w_brk) begin
                    if (n_count != '0) begin
                        n_seq = sln_pkg::S_REPLAY;
                    end else if (r_cur_end) begin
                        n_seq = sln_pkg::S_END;
                    end else begin
                        n_seq = sln_pkg::S_BYTE;
                    end
                end else if (r_cur_end) begin
                    n_seq = sln_pkg::S_END;
                end else if (r_phase == sln_pkg::PH_EMIT || r_phase == sln_pkg::PH_FULL) begin
                    n_seq = sln_pkg::S_BYTE;
                end else begin
                    n_seq = sln_pkg::S_IDLE;
                end
            end
            sln_pkg::S_REPLAY: begin
                if (w_go && s_done && (SW'(r_idx) + SW'(1) == r_count)) begin
                    n_seq = r_cur_end ? sln_pkg::S_END : sln_pkg::S_BYTE;
                end
            end
            sln_pkg::S_BYTE: begin
                if (w_go && s_done) begin
                    n_seq = sln_pkg::S_FLUSH;
                end
            end
            sln_pkg::S_END: begin
                if (w_go) begin
                    n_seq = sln_pkg::S_FLUSH;
                end
            end
            sln_pkg::S_FLUSH: begin
                if (!r_hold_valid || w_slot) begin
                    n_seq = sln_pkg::S_IDLE;
                end
            end
            default: begin
                n_seq = sln_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= sln_pkg::S_IDLE;
            r_phase      <= sln_pkg::PH_SKIPWS;
            r_scan       <= '0;
            r_written    <= '0;
            r_lastsp     <= '0;
            r_pending    <= 1'b0;
            r_rewind     <= 1'b0;
            r_recent     <= '0;
            r_idx        <= '0;
            r_count      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_seq        <= n_seq;
            r_phase      <= n_phase;
            r_scan       <= n_scan;
            r_written    <= n_written;
            r_lastsp     <= n_lastsp;
            r_pending    <= n_pending;
            r_rewind     <= n_rewind;
            r_recent     <= n_recent;
            r_idx        <= n_idx;
            r_count      <= n_count;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur_byte  <= n_cur_byte;
        r_cur_end   <= n_cur_end;
        r_hold_kind <= n_hold_kind;
        r_hold_char <= n_hold_char;
        r_hold_len  <= n_hold_len;
        r_out_kind  <= n_out_kind;
        r_out_char  <= n_out_char;
        r_out_len   <= n_out_len;
        r_out_last  <= n_out_last;
    end

    // replay buffer write
    always_ff @(posedge i_clk) begin
        if (w_store && p_scan < SW'(sln_pkg::BUF_DEPTH)) begin
            r_buf[AW'(p_scan)] <= w_store_byte;
        end
    end

`ifndef SYNTH
    a_hold_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == sln_pkg::S_IDLE) |-> !r_hold_valid)
        else $error("held result left behind when idle");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= SW'(sln_pkg::BUF_DEPTH))
        else $error("prefix scan offset beyond buffer depth");

    a_written_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_written <= CW'(sln_pkg::OUT_LIMIT))
        else $error("written count beyond output limit");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == sln_pkg::KIND_END) |-> r_out_last)
        else $error("end word not flagged last");

    a_replay_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == sln_pkg::S_REPLAY) |-> (SW'(r_idx) < r_count))
        else $error("replay index past buffered count");
`endif

endmodule
`default_nettype wire
